// ===== rtl/qdc_pkg.sv =====
// Shared types, constants and the transition table of the quadrature detent counter.
package qdc_pkg;

  localparam int ValueWidth = 8;
  localparam int AbWidth    = 2;
  localparam int CfgIdxWidth = 2;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [AbWidth-1:0]            ab_t;
  typedef logic [1:0]                    phase_t;
  typedef logic signed [1:0]             step_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MIN_VALUE   = 2'd0,
    REG_MAX_VALUE   = 2'd1,
    REG_START_VALUE = 2'd2
  } cfg_reg_t;

  localparam value_t MinValueReset   = 8'sd1;
  localparam value_t MaxValueReset   = 8'sd16;
  localparam value_t StartValueReset = 8'sd16;
  localparam ab_t    PrevAbReset     = 2'd0;
  localparam phase_t PhaseReset      = 2'd1;
  localparam phase_t PhaseTop        = 2'd3;
  localparam phase_t PhaseBottom     = 2'd0;

  // Raw step for the index {previous_ab, ab}; both lines changing gives no step.
  localparam step_t StepTable [16] = '{
     2'sd0,  2'sd1, -2'sd1,  2'sd0,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
     2'sd0, -2'sd1,  2'sd1,  2'sd0
  };

endpackage

// ===== rtl/quadrature_detent_counter_core.sv =====
// Quadrature detent counter: decodes A/B samples into a clamped detent value.
//
// One item enters per clock while in_ready is high. An accepted item goes into an
// input register, is decoded from it against the encoder state once the output
// register is free, and its result is held in the output register until
// transferred. The input register takes an item while a result waits only when
// it is empty, so one input transfer can happen under output backpressure.
// The value moves by one each time the raw quadrature count crosses a multiple
// of four, and is clamped to [min_value, max_value] (minimum tested first).
// A restart item loads start_value unclamped and takes ab as the previous
// sample. Configuration writes are always accepted and written to their registers.
module quadrature_detent_counter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qdc_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [qdc_pkg::ValueWidth-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [qdc_pkg::AbWidth-1:0]          ab,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qdc_pkg::ValueWidth-1:0] value,
  output logic                                 moved,
  output logic                                 report
);

  qdc_pkg::value_t min_value, max_value, start_value;
  qdc_pkg::ab_t    previous_ab;
  qdc_pkg::phase_t raw_phase;
  qdc_pkg::value_t detent_value;

  logic            stage_valid;
  logic            stage_action;
  qdc_pkg::ab_t    stage_ab;

  logic            advance;
  qdc_pkg::step_t  step;
  logic signed [1:0] delta;
  logic signed [qdc_pkg::ValueWidth:0] sum, lo, hi, clamped;
  qdc_pkg::value_t value_next;
  qdc_pkg::phase_t raw_phase_next;
  logic            moved_next, report_next;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  always_comb begin
    step  = qdc_pkg::StepTable[{previous_ab, stage_ab}];
    delta = 2'sd0;
    if (step > 2'sd0 && raw_phase == qdc_pkg::PhaseTop) begin
      delta = 2'sd1;
    end else if (step < 2'sd0 && raw_phase == qdc_pkg::PhaseBottom) begin
      delta = -2'sd1;
    end
    raw_phase_next = raw_phase + qdc_pkg::phase_t'(step);
    sum = {detent_value[qdc_pkg::ValueWidth-1], detent_value}
          + {{(qdc_pkg::ValueWidth-1){delta[1]}}, delta};
    lo  = {min_value[qdc_pkg::ValueWidth-1], min_value};
    hi  = {max_value[qdc_pkg::ValueWidth-1], max_value};
    priority if (sum < lo) begin
      clamped = lo;
    end else if (sum > hi) begin
      clamped = hi;
    end else begin
      clamped = sum;
    end
    if (stage_action) begin
      value_next  = start_value;
      moved_next  = 1'b0;
      report_next = 1'b0;
    end else begin
      value_next  = clamped[qdc_pkg::ValueWidth-1:0];
      moved_next  = (previous_ab != stage_ab);
      report_next = moved_next && (value_next != detent_value
                    || clamped == lo || clamped == hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value    <= qdc_pkg::MinValueReset;
      max_value    <= qdc_pkg::MaxValueReset;
      start_value  <= qdc_pkg::StartValueReset;
      previous_ab  <= qdc_pkg::PrevAbReset;
      raw_phase    <= qdc_pkg::PhaseReset;
      detent_value <= qdc_pkg::StartValueReset;
      stage_valid  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          qdc_pkg::REG_MIN_VALUE:   min_value   <= cfg_data;
          qdc_pkg::REG_MAX_VALUE:   max_value   <= cfg_data;
          qdc_pkg::REG_START_VALUE: start_value <= cfg_data;
          default: ;
        endcase
      end
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        detent_value <= value_next;
        previous_ab  <= stage_ab;
        if (!stage_action) begin
          raw_phase <= raw_phase_next;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_action <= action;
      stage_ab     <= ab;
    end
    if (advance) begin
      value  <= value_next;
      moved  <= moved_next;
      report <= report_next;
    end
  end

endmodule
